[design/fdsu_pkg.sv]
// Package: types, op codes and constants for the Forth data stack unit.
`default_nettype none
package fdsu_pkg;
  localparam int STACK_DEPTH = 256;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
    OP_MOD = 5'd5, OP_DUP = 5'd6, OP_DROP = 5'd7, OP_SWAP = 5'd8, OP_OVER = 5'd9,
    OP_ROT = 5'd10, OP_EQ = 5'd11, OP_LT = 5'd12, OP_GT = 5'd13, OP_AND = 5'd14,
    OP_OR = 5'd15, OP_INVERT = 5'd16, OP_PRINT = 5'd17, OP_EMIT = 5'd18,
    OP_CR = 5'd19
  } op_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;
  localparam logic [1:0] KIND_NL   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam int QDEPTH = 2;

  // classified word passed from front to back
  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] literal;
    logic [1:0]  npop;
    logic [1:0]  npush;
    logic        is_div;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RDWAIT, S_EXEC, S_DIV, S_WR, S_OUT
  } state_t;
endpackage
`default_nettype wire

[design/fdsu_if.sv]
// Valid/ready interfaces for the input and result channels.
`default_nettype none
interface fdsu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic signed [31:0] literal;
  modport source (output valid, op, literal, input ready);
  modport sink (input valid, op, literal, output ready);
endinterface

interface fdsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic signed [31:0] out_value;
  logic [8:0]  stack_depth_now;
  logic [1:0]  status;
  modport source (output valid, out_kind, out_value, stack_depth_now, status, input ready);
  modport sink (input valid, out_kind, out_value, stack_depth_now, status, output ready);
endinterface
`default_nettype wire

[design/forth_data_stack_unit_top.sv]
// Forth data stack unit: executes one primitive per input word on a 32-bit cell stack.
// Input channel in_ch carries op and literal; result channel out_ch carries
// out_kind, out_value, stack_depth_now and status, one result word per input.
// A front end classifies each word into a two-entry queue; the back end reads
// operands from the stack RAM (one per cycle, registered read), executes,
// writes pushed cells back one per cycle and presents the result.
// Div and mod with a nonzero divisor also pass through the divider (one quotient
// bit per cycle). Only the operands present on the stack are read. The back end
// finishes each word before it takes the next; the queue can take words meanwhile.
// Reset empties the stack (depth zero); cell contents are not cleared.
// A stalled result holds on out_ch; the queue keeps taking words until full.
`default_nettype none
module forth_data_stack_unit_top import fdsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  fdsu_in_if.sink   in_ch,
  fdsu_out_if.source out_ch
);
  cmd_t cmd;
  logic cmd_valid, cmd_take;

  fdsu_front u_front (.clk(clk), .rst(rst), .in_ch(in_ch), .cmd(cmd),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take));
  fdsu_back u_back (.clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .out_ch(out_ch));
endmodule
`default_nettype wire

[design/fdsu_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module fdsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/fdsu_front.sv]
// Front end: accepts words, classifies operand counts, small queue to back end.
`default_nettype none
module fdsu_front import fdsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  fdsu_in_if.sink   in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_take
);
  cmd_t q [QDEPTH];
  logic rp, wp;
  logic [1:0] cnt;
  cmd_t c;

  always_comb begin
    c.op = in_ch.op;
    c.literal = in_ch.literal;
    c.is_div = 1'b0;
    case (op_t'(in_ch.op))
      OP_PUSH: begin c.npop = 2'd0; c.npush = 2'd1; end
      OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR: begin
        c.npop = 2'd2; c.npush = 2'd1;
      end
      OP_DIV, OP_MOD: begin c.npop = 2'd2; c.npush = 2'd1; c.is_div = 1'b1; end
      OP_DUP: begin c.npop = 2'd1; c.npush = 2'd2; end
      OP_DROP, OP_PRINT, OP_EMIT: begin c.npop = 2'd1; c.npush = 2'd0; end
      OP_SWAP: begin c.npop = 2'd2; c.npush = 2'd2; end
      OP_OVER, OP_ROT: begin c.npop = (in_ch.op == OP_ROT) ? 2'd3 : 2'd2; c.npush = 2'd3; end
      OP_INVERT: begin c.npop = 2'd1; c.npush = 2'd1; end
      default: begin c.npop = 2'd0; c.npush = 2'd0; end
    endcase
  end

  assign in_ch.ready = (cnt != 2'(QDEPTH));
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) q[wp] <= c;
    if (rst) begin
      rp <= 1'b0; wp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wp <= ~wp;
      if (cmd_valid && cmd_take) rp <= ~rp;
      cnt <= cnt + 2'(in_ch.valid && in_ch.ready) - 2'(cmd_valid && cmd_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'(QDEPTH))
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_take && !(in_ch.valid && in_ch.ready)) |=> cnt == $past(cnt) - 2'd1)
    else $error("queue count not decremented");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !cmd_take || !cmd_valid)
    else $error("take from empty queue");
endmodule
`default_nettype wire

[design/fdsu_div.sv]
// Radix-2 restoring divider, signed truncating, one quotient bit per cycle.
`default_nettype none
module fdsu_div import fdsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] n,
  input  wire logic [31:0] d,
  output logic             done,
  output logic [31:0]      quo,
  output logic [31:0]      rem
);
  logic [31:0] dm, qr, rr;
  logic [32:0] trial;
  logic [5:0]  cnt;
  logic        busy, nneg, qneg;

  assign trial = {rr, qr[31]} - {1'b0, dm};
  assign quo = qneg ? (32'd0 - qr) : qr;
  assign rem = nneg ? (32'd0 - rr) : rr;

  always_ff @(posedge clk) begin
    if (start) begin
      dm <= d[31] ? (32'd0 - d) : d;
      qr <= n[31] ? (32'd0 - n) : n;
      rr <= 32'd0;
      nneg <= n[31];
      qneg <= n[31] ^ d[31];
    end else if (busy) begin
      if (!trial[32]) rr <= trial[31:0];
      else rr <= {rr[30:0], qr[31]};
      qr <= {qr[30:0], !trial[32]};
    end
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin busy <= 1'b0; done <= 1'b1; end
      end
    end
  end
endmodule
`default_nettype wire

[design/fdsu_back.sv]
// Back end: reads operands from the stack RAM, executes, writes back, emits result.
`default_nettype none
module fdsu_back import fdsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      cmd,
  input  wire logic cmd_valid,
  output logic      cmd_take,
  fdsu_out_if.source out_ch
);
  state_t state, state_next;
  cmd_t   cur;
  logic [DW-1:0] depth, dwork;
  logic [31:0] a, b, c, r0, r1, r2, mulp;
  logic [1:0]  rdi, wri, nread;
  logic        under, divz, over;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic        dstart, ddone;
  logic [31:0] dq, dr;
  logic        rvalid;

  fdsu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));
  fdsu_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .n(b), .d(a), .done(ddone), .quo(dq), .rem(dr));

  // number of operands actually present
  assign nread = (depth >= DW'(cur.npop)) ? cur.npop : depth[1:0];
  assign raddr = AW'(depth - DW'(rdi) - DW'(1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (cmd_valid) state_next = S_RD0;
      S_RD0:    state_next = (rdi == nread) ? S_EXEC : S_RDWAIT;
      S_RDWAIT: state_next = (rdi == nread) ? S_EXEC : S_RDWAIT;
      S_EXEC:   state_next = (cur.is_div && a != 32'd0) ? S_DIV : S_WR;
      S_DIV:    if (ddone) state_next = S_WR;
      S_WR:     if (wri == cur.npush) state_next = S_OUT;
      S_OUT:    if (out_ch.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (state == S_IDLE) && cmd_valid;
    dstart = (state == S_EXEC) && cur.is_div && a != 32'd0;
    out_ch.valid = (state == S_OUT);
    we = 1'b0;
    waddr = AW'(dwork);
    wdata = r0;
    if (state == S_WR && wri != cur.npush && dwork < DW'(STACK_DEPTH)) we = 1'b1;
    case (wri)
      2'd0: wdata = r0;
      2'd1: wdata = r1;
      default: wdata = r2;
    endcase
  end

  assign mulp = b * a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; depth <= '0; rvalid <= 1'b0;
    end else begin
      state <= state_next;
      rvalid <= (state == S_RD0 || state == S_RDWAIT) && rdi != nread;
      if (state == S_OUT && out_ch.ready) depth <= dwork;
    end
    case (state)
      S_IDLE: begin
        cur <= cmd; rdi <= 2'd0; wri <= 2'd0;
        a <= 32'hFFFFFFFF; b <= 32'hFFFFFFFF; c <= 32'hFFFFFFFF;
        under <= 1'b0; divz <= 1'b0; over <= 1'b0;
      end
      S_RD0, S_RDWAIT: begin
        if (rvalid) begin
          case (rdi - 2'd1)
            2'd0: a <= rdata;
            2'd1: b <= rdata;
            default: c <= rdata;
          endcase
        end
        if (rdi != nread) rdi <= rdi + 2'd1;
        if (rdi == nread) begin
          dwork <= depth - DW'(nread);
          under <= (nread != cur.npop);
        end
      end
      S_EXEC: begin
        r1 <= a; r2 <= b;
        case (op_t'(cur.op))
          OP_PUSH:   r0 <= cur.literal;
          OP_ADD:    r0 <= b + a;
          OP_SUB:    r0 <= b - a;
          OP_MUL:    r0 <= mulp;
          OP_DIV, OP_MOD: begin r0 <= 32'd0; divz <= (a == 32'd0); end
          OP_DUP:    begin r0 <= a; r1 <= a; end
          OP_SWAP:   begin r0 <= a; r1 <= b; end
          OP_OVER:   begin r0 <= b; r1 <= a; r2 <= b; end
          OP_ROT:    begin r0 <= b; r1 <= a; r2 <= c; end
          OP_EQ:     r0 <= (b == a) ? 32'hFFFFFFFF : 32'd0;
          OP_LT:     r0 <= ($signed(b) < $signed(a)) ? 32'hFFFFFFFF : 32'd0;
          OP_GT:     r0 <= ($signed(a) < $signed(b)) ? 32'hFFFFFFFF : 32'd0;
          OP_AND:    r0 <= b & a;
          OP_OR:     r0 <= b | a;
          OP_INVERT: r0 <= ~a;
          OP_EMIT:   r0 <= {24'd0, a[7:0]};
          default:   r0 <= a;
        endcase
      end
      S_DIV: if (ddone) r0 <= (cur.op == OP_DIV) ? dq : dr;
      S_WR: if (wri != cur.npush) begin
        wri <= wri + 2'd1;
        if (dwork < DW'(STACK_DEPTH)) dwork <= dwork + DW'(1);
        else over <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_ch.out_value = 32'd0;
    case (op_t'(cur.op))
      OP_PRINT: out_ch.out_kind = KIND_NUM;
      OP_EMIT:  out_ch.out_kind = KIND_CHAR;
      OP_CR:    out_ch.out_kind = KIND_NL;
      default:  out_ch.out_kind = KIND_NONE;
    endcase
    if (cur.op == OP_PRINT || cur.op == OP_EMIT) out_ch.out_value = r0;
    out_ch.stack_depth_now = 9'(dwork);
    out_ch.status = under ? ST_UNDER : divz ? ST_DIVZ : over ? ST_OVER : ST_OK;
  end

  assert property (@(posedge clk) disable iff (rst) depth <= DW'(STACK_DEPTH))
    else $error("depth beyond stack size");
  assert property (@(posedge clk) disable iff (rst) we |-> state == S_WR)
    else $error("write outside write-back");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_ch.ready) |=> state == S_OUT && $stable(dwork))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

[sim/fdsu_checker.sv]
// Checker for the Forth data stack unit: predicts each result word and compares it.
`timescale 1ns / 100ps
module fdsu_checker import fdsu_pkg::*; (
  input logic clk,
  input logic rst,
  fdsu_in_if.sink in_mon,
  fdsu_out_if.sink out_mon,
  output int fail_count,
  output int pending,
  output int results_seen
);
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [8:0]  depth;
    logic [1:0]  status;
  } result_t;

  logic [31:0] cells [STACK_DEPTH];
  int unsigned sp;
  bit under_f, over_f, divz_f;
  result_t expected_q [$];

  assign pending = expected_q.size();

  function automatic logic [31:0] pop_cell();
    if (sp == 0) begin
      under_f = 1;
      return 32'hFFFF_FFFF;
    end
    sp--;
    return cells[sp];
  endfunction

  function automatic void push_cell(logic [31:0] v);
    if (sp >= STACK_DEPTH) begin
      over_f = 1;
      return;
    end
    cells[sp] = v;
    sp++;
  endfunction

  function automatic result_t execute(logic [4:0] op, logic [31:0] lit);
    logic [31:0] a, b, c, ma, mb, q;
    result_t r;
    r = '0;
    under_f = 0; over_f = 0; divz_f = 0;
    case (op)
      OP_PUSH: push_cell(lit);
      OP_ADD: begin a = pop_cell(); b = pop_cell(); push_cell(b + a); end
      OP_SUB: begin a = pop_cell(); b = pop_cell(); push_cell(b - a); end
      OP_MUL: begin a = pop_cell(); b = pop_cell(); push_cell(b * a); end
      OP_DIV, OP_MOD: begin
        a = pop_cell(); b = pop_cell();
        if (a == 0) begin
          divz_f = 1;
          push_cell(0);
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          if (op == OP_DIV) begin
            q = mb / ma;
            push_cell((a[31] != b[31]) ? -q : q);
          end else begin
            q = mb % ma;
            push_cell(b[31] ? -q : q);
          end
        end
      end
      OP_DUP: begin a = pop_cell(); push_cell(a); push_cell(a); end
      OP_DROP: a = pop_cell();
      OP_SWAP: begin a = pop_cell(); b = pop_cell(); push_cell(a); push_cell(b); end
      OP_OVER: begin
        a = pop_cell(); b = pop_cell(); push_cell(b); push_cell(a); push_cell(b);
      end
      OP_ROT: begin
        a = pop_cell(); b = pop_cell(); c = pop_cell();
        push_cell(b); push_cell(a); push_cell(c);
      end
      OP_EQ: begin
        a = pop_cell(); b = pop_cell();
        push_cell((b == a) ? 32'hFFFF_FFFF : 32'd0);
      end
      OP_LT: begin
        a = pop_cell(); b = pop_cell();
        push_cell(($signed(b) < $signed(a)) ? 32'hFFFF_FFFF : 32'd0);
      end
      OP_GT: begin
        a = pop_cell(); b = pop_cell();
        push_cell(($signed(b) > $signed(a)) ? 32'hFFFF_FFFF : 32'd0);
      end
      OP_AND: begin a = pop_cell(); b = pop_cell(); push_cell(b & a); end
      OP_OR: begin a = pop_cell(); b = pop_cell(); push_cell(b | a); end
      OP_INVERT: begin a = pop_cell(); push_cell(~a); end
      OP_PRINT: begin r.kind = KIND_NUM; r.value = pop_cell(); end
      OP_EMIT: begin a = pop_cell(); r.kind = KIND_CHAR; r.value = {24'd0, a[7:0]}; end
      OP_CR: r.kind = KIND_NL;
      default: ;
    endcase
    r.status = under_f ? ST_UNDER : divz_f ? ST_DIVZ : over_f ? ST_OVER : ST_OK;
    r.depth = sp[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      sp = 0;
      fail_count <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(execute(in_mon.op, in_mon.literal));
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_mon.out_kind !== e.kind) begin
            $error("out_kind exp %0d got %0d", e.kind, out_mon.out_kind);
            fail_count <= fail_count + 1;
          end
          if (out_mon.out_value !== e.value) begin
            $error("out_value exp %0d got %0d", $signed(e.value), out_mon.out_value);
            fail_count <= fail_count + 1;
          end
          if (out_mon.stack_depth_now !== e.depth) begin
            $error("stack_depth_now exp %0d got %0d", e.depth, out_mon.stack_depth_now);
            fail_count <= fail_count + 1;
          end
          if (out_mon.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_mon.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[sim/testbench.sv]
// Testbench top: clock, reset, op stream with random idling, and the verdict.
`timescale 1ns / 100ps
module testbench;
  import fdsu_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int fail_count, pending, results_seen;
  int send_idle_pct, recv_idle_pct;
  int sent;

  fdsu_in_if in_ch();
  fdsu_out_if out_ch();

  forth_data_stack_unit_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  fdsu_checker chk (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen));

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.op = '0;
    in_ch.literal = '0;
    out_ch.ready = 0;
  end

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 0;
      4: return $urandom_range(20) - 10;
      default: return $urandom();
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_word(logic [4:0] op, logic [31:0] lit);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.op <= op;
    in_ch.literal <= lit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic random_phase(int n, ref int depth);
    logic [4:0] op;
    repeat (n) begin
      if ($urandom_range(99) < 3) op = 5'($urandom_range(31));
      else if (depth < 4 || ($urandom_range(3) == 0 && depth < 200)) op = OP_PUSH;
      else op = 5'($urandom_range(19));
      send_word(op, pick_value());
      // rough tracking of depth to keep most ops fed
      case (op)
        OP_PUSH, OP_DUP, OP_OVER: depth++;
        OP_DROP, OP_PRINT, OP_EMIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
        OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR: depth = (depth > 0) ? depth - 1 : 0;
        default: ;
      endcase
    end
  endtask

  initial begin
    int depth;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // underflow on empty stack, then arithmetic edge cases
    send_word(OP_DROP, 0);
    send_word(OP_ROT, 0);
    send_word(OP_PRINT, 0);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_DIV, 0);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_MOD, 0);
    send_word(OP_PUSH, 7);
    send_word(OP_PUSH, 0);
    send_word(OP_DIV, 0);
    send_word(OP_PUSH, -7);
    send_word(OP_PUSH, 2);
    send_word(OP_MOD, 0);
    send_word(OP_PUSH, 32'h7FFF_FFFF);
    send_word(OP_EMIT, 0);
    send_word(OP_CR, 0);
    send_word(OP_OVER, 0);
    send_word(OP_LT, 0);
    send_word(5'd25, 0);
    send_word(5'd31, 32'h5555_AAAA);
    // fill to overflow
    for (int i = 0; i < STACK_DEPTH + 2; i++) send_word(OP_PUSH, $urandom());
    send_word(OP_DUP, 0);
    send_word(OP_OVER, 0);
    for (int i = 0; i < STACK_DEPTH + 4; i++) send_word(OP_DROP, 0);

    depth = 0;
    send_idle_pct = 37; recv_idle_pct = 67;
    random_phase(350, depth);
    send_idle_pct = 67; recv_idle_pct = 37;
    random_phase(350, depth);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(360, depth);
    in_ch.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d op words, %0d result words checked, incl. underflow,", sent, results_seen);
    $display("overflow, zero divisor and wrap cases under three idling mixes.");
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
